FILE: src/ipv4tx_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 transmit header builder package
// Fixed header constants, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package ipv4tx_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LOCAL_ADDRESS   = 2'd0;
    localparam logic [1:0] CFG_SUBNET_MASK     = 2'd1;
    localparam logic [1:0] CFG_GATEWAY_ADDRESS = 2'd2;

    // Fixed header fields.
    localparam logic [7:0]  VER_IHL     = 8'h45;
    localparam logic [7:0]  TTL_DEFAULT = 8'd64;
    localparam logic [15:0] HDR_BYTES   = 16'd20;
    localparam int          HDR_WORDS   = 5;

    // Reset values of the configuration registers.
    localparam logic [31:0] RESET_LOCAL_ADDRESS   = 32'h0A00_020F;
    localparam logic [31:0] RESET_SUBNET_MASK     = 32'hFFFF_FF00;
    localparam logic [31:0] RESET_GATEWAY_ADDRESS = 32'h0A00_0202;
    localparam logic [15:0] RESET_IDENT           = 16'd1;

    // Header word storage type.
    typedef logic [31:0] hdr_word_t;

endpackage

FILE: src/ipv4_tx_header_builder.sv
// ----------------------------------------------------------------------------
// IPv4 transmit header builder
// Builds the 20-byte IPv4 header with checksum and next hop for each legal request.
// ----------------------------------------------------------------------------
// Each accepted request of legal length produces five header words in network
// order on the output channel, one word per cycle while out_stall is low; the
// single 32-bit output channel limits the sustained request rate. The request
// waits in an input register; header, checksum and next hop are computed in
// one pass when it moves into the header buffer, and the next request is
// taken into the input register while the current header is still being sent.
// A request whose payload exceeds MAX_PACKET-20 yields a single error
// transaction and does not advance the identification counter.
// When the header buffer is free, the request passes through the input register
// into the header buffer before the first word is valid on the output channel.
module ipv4_tx_header_builder #(
    parameter int MAX_PACKET = 1500
) (
    input  logic        clk,
    input  logic        rst_n,
    // Request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] destination_address,
    input  logic [7:0]  protocol_number,
    input  logic [15:0] payload_bytes,
    // Result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] header_word,
    output logic [2:0]  word_number,
    output logic        last_word,
    output logic [31:0] forward_address,
    output logic        length_error,
    // Configuration port
    input  logic        cfg_write_enable,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam logic [15:0] LIMIT = 16'(MAX_PACKET - 20);
    localparam logic [2:0]  LAST_IDX = 3'(ipv4tx_pkg::HDR_WORDS - 1);

    // Configuration and identification state.
    logic [31:0] local_address_reg;
    logic [31:0] subnet_mask_reg;
    logic [31:0] gateway_address_reg;
    logic [15:0] ident_reg;

    // Input register.
    logic        in_valid_reg;
    logic [31:0] dst_reg;
    logic [7:0]  proto_reg;
    logic [15:0] plen_reg;

    // Header buffer and serializer.
    logic                  hdr_valid_reg;
    ipv4tx_pkg::hdr_word_t word_reg [ipv4tx_pkg::HDR_WORDS];
    logic [31:0]           hop_reg;
    logic                  err_reg;
    logic [2:0]            idx_reg;

    logic        in_accept;
    logic        out_accept;
    logic        out_last;
    logic        load;
    logic        too_long;
    logic [15:0] total_len;
    logic [18:0] sum_raw;
    logic [16:0] sum_fold1;
    logic [15:0] sum_fold2;
    logic [15:0] checksum;
    logic [31:0] hop_next;

    // Handshake control.
    assign out_last   = err_reg || (idx_reg == LAST_IDX);
    assign out_accept = hdr_valid_reg && !out_stall;
    assign load       = in_valid_reg && (!hdr_valid_reg || (out_accept && out_last));
    assign in_stall   = in_valid_reg && !load;
    assign in_accept  = in_valid && !in_stall;

    // Header fields, checksum and next hop for the buffered request.
    assign too_long  = plen_reg > LIMIT;
    assign total_len = ipv4tx_pkg::HDR_BYTES + plen_reg;
    assign sum_raw   = 19'({ipv4tx_pkg::VER_IHL, 8'h00})
                     + 19'(total_len)
                     + 19'(ident_reg)
                     + 19'({ipv4tx_pkg::TTL_DEFAULT, proto_reg})
                     + 19'(local_address_reg[31:16])
                     + 19'(local_address_reg[15:0])
                     + 19'(dst_reg[31:16])
                     + 19'(dst_reg[15:0]);
    assign sum_fold1 = 17'(sum_raw[15:0]) + 17'(sum_raw[18:16]);
    assign sum_fold2 = sum_fold1[15:0] + 16'(sum_fold1[16]);
    assign checksum  = ~sum_fold2;
    assign hop_next  = (((dst_reg ^ local_address_reg) & subnet_mask_reg) == 32'd0)
                     ? dst_reg : gateway_address_reg;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg   <= ipv4tx_pkg::RESET_LOCAL_ADDRESS;
            subnet_mask_reg     <= ipv4tx_pkg::RESET_SUBNET_MASK;
            gateway_address_reg <= ipv4tx_pkg::RESET_GATEWAY_ADDRESS;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                ipv4tx_pkg::CFG_LOCAL_ADDRESS:   local_address_reg   <= cfg_data;
                ipv4tx_pkg::CFG_SUBNET_MASK:     subnet_mask_reg     <= cfg_data;
                ipv4tx_pkg::CFG_GATEWAY_ADDRESS: gateway_address_reg <= cfg_data;
                default:                         ;
            endcase
        end
    end

    // Identification counter advances on each valid header built.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ident_reg <= ipv4tx_pkg::RESET_IDENT;
        else if (load && !too_long)
            ident_reg <= ident_reg + 16'd1;
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_accept)
            in_valid_reg <= 1'b1;
        else if (load)
            in_valid_reg <= 1'b0;
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            dst_reg   <= destination_address;
            proto_reg <= protocol_number;
            plen_reg  <= payload_bytes;
        end
    end

    // Header buffer control and word index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else if (load)
        begin
            hdr_valid_reg <= 1'b1;
            idx_reg       <= 3'd0;
        end
        else if (out_accept)
        begin
            if (out_last)
                hdr_valid_reg <= 1'b0;
            idx_reg <= idx_reg + 3'd1;
        end
    end

    // Header buffer payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg[0] <= {ipv4tx_pkg::VER_IHL, 8'h00, total_len};
            word_reg[1] <= {ident_reg, 16'h0000};
            word_reg[2] <= {ipv4tx_pkg::TTL_DEFAULT, proto_reg, checksum};
            word_reg[3] <= local_address_reg;
            word_reg[4] <= dst_reg;
            hop_reg     <= hop_next;
            err_reg     <= too_long;
        end
    end

    // Result channel outputs; an error result carries zero fields.
    always_comb
    begin
        out_valid    = hdr_valid_reg;
        last_word    = out_last;
        length_error = err_reg;
        if (err_reg)
        begin
            header_word     = 32'd0;
            word_number     = 3'd0;
            forward_address = 32'd0;
        end
        else
        begin
            header_word     = (idx_reg <= LAST_IDX) ? word_reg[idx_reg] : 32'd0;
            word_number     = idx_reg;
            forward_address = hop_reg;
        end
    end

`ifndef ASSERT_OFF
    // The input side only stalls while a request is held.
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
        else $error("input stalled with empty input register");

    // The last word is either the error result or word four.
    a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_word) |-> (length_error || word_number == LAST_IDX))
        else $error("last word flagged at wrong position");

    // An error result is alone and carries a zero word.
    a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && length_error) |-> (last_word && header_word == 32'd0))
        else $error("malformed error result");

    // The counter moves by one when a good header is built.
    a_ident_step: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !too_long) |=> (ident_reg == $past(ident_reg) + 16'd1))
        else $error("identification counter did not advance");

    // The word index never passes the last header word.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_valid_reg |-> (idx_reg <= LAST_IDX))
        else $error("word index out of range");
`endif

endmodule

FILE: tb/ipv4_tx_header_checker.sv
// ----------------------------------------------------------------------------
// IPv4 transmit header checker
// Watches the request, result and configuration ports of the header builder,
// predicts the header words of every accepted request and compares them.
// ----------------------------------------------------------------------------
module ipv4_tx_header_checker #(
    parameter int MAX_PACKET = 1500
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [31:0] destination_address,
    input  logic [7:0]  protocol_number,
    input  logic [15:0] payload_bytes,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] header_word,
    input  logic [2:0]  word_number,
    input  logic        last_word,
    input  logic [31:0] forward_address,
    input  logic        length_error,
    input  logic        cfg_write_enable,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          pending_results,
    output int          failures
);

    localparam int PAYLOAD_LIMIT = MAX_PACKET - int'(ipv4tx_pkg::HDR_BYTES);

    // One result transaction as the block should present it.
    typedef struct packed {
        ipv4tx_pkg::hdr_word_t word;
        logic [2:0]            number;
        logic                  last;
        logic [31:0]           hop;
        logic                  error;
    } header_result_t;

    // Shadow copy of the configuration and the identification counter.
    logic [31:0]    own_address;
    logic [31:0]    mask;
    logic [31:0]    gateway;
    logic [15:0]    ident_next;
    header_result_t header_words_due[$];
    int             fail_count = 0;

    // Queue the header words (or the single error word) for one request.
    task automatic build_expected_header(input logic [31:0] dst, input logic [7:0] proto,
                                         input logic [15:0] len);
        ipv4tx_pkg::hdr_word_t words [ipv4tx_pkg::HDR_WORDS];
        logic [31:0]           sum;
        logic [31:0]           hop;
        header_result_t        item;
        int                    k;
        if (int'(len) > PAYLOAD_LIMIT)
        begin
            item = '{'0, 3'd0, 1'b1, 32'd0, 1'b1};
            header_words_due.push_back(item);
        end
        else
        begin
            words[0] = {ipv4tx_pkg::VER_IHL, 8'h00, ipv4tx_pkg::HDR_BYTES + len};
            words[1] = {ident_next, 16'h0000};
            words[2] = {ipv4tx_pkg::TTL_DEFAULT, proto, 16'h0000};
            words[3] = own_address;
            words[4] = dst;

            // Ones' complement sum of the ten 16-bit halves, folded twice.
            sum = '0;
            for (k = 0; k < ipv4tx_pkg::HDR_WORDS; k++)
                sum = sum + words[k][31:16] + words[k][15:0];
            sum = {16'h0000, sum[15:0]} + {16'h0000, sum[31:16]};
            sum = {16'h0000, sum[15:0]} + {16'h0000, sum[31:16]};
            words[2][15:0] = ~sum[15:0];

            ident_next = ident_next + 16'd1;
            hop = (((dst ^ own_address) & mask) == 32'd0) ? dst : gateway;

            for (k = 0; k < ipv4tx_pkg::HDR_WORDS; k++)
            begin
                item = '{words[k], 3'(k), 1'(k == ipv4tx_pkg::HDR_WORDS - 1), hop, 1'b0};
                header_words_due.push_back(item);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, want, got);
            fail_count++;
        end
    endtask

    // All ports are sampled at the rising edge, before any update of that edge.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        header_result_t due;
        if (!rst_n)
        begin
            own_address = ipv4tx_pkg::RESET_LOCAL_ADDRESS;
            mask        = ipv4tx_pkg::RESET_SUBNET_MASK;
            gateway     = ipv4tx_pkg::RESET_GATEWAY_ADDRESS;
            ident_next  = ipv4tx_pkg::RESET_IDENT;
            header_words_due.delete();
            pending_results <= 0;
            failures        <= fail_count;
        end
        else
        begin
            // Register writes; an index with no register is ignored.
            if (cfg_write_enable)
            begin
                case (cfg_index)
                    ipv4tx_pkg::CFG_LOCAL_ADDRESS:   own_address = cfg_data;
                    ipv4tx_pkg::CFG_SUBNET_MASK:     mask        = cfg_data;
                    ipv4tx_pkg::CFG_GATEWAY_ADDRESS: gateway     = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                build_expected_header(destination_address, protocol_number, payload_bytes);

            // Compare each result transaction with the oldest prediction.
            if (out_valid && !out_stall)
            begin
                if (header_words_due.size() == 0)
                begin
                    $error("unexpected result transaction: header_word 0x%08h", header_word);
                    fail_count++;
                end
                else
                begin
                    due = header_words_due.pop_front();
                    check_field("header_word", due.word, header_word);
                    check_field("word_number", 32'(due.number), 32'(word_number));
                    check_field("last_word", 32'(due.last), 32'(last_word));
                    check_field("forward_address", due.hop, forward_address);
                    check_field("length_error", 32'(due.error), 32'(length_error));
                end
            end

            pending_results <= header_words_due.size();
            failures        <= fail_count;
        end
    end

endmodule

FILE: tb/ipv4_tx_header_builder_tb.sv
// ----------------------------------------------------------------------------
// IPv4 transmit header builder testbench
// Drives directed and random send requests through several register settings,
// with random sender gaps and receiver stalls, and reports the checker verdict.
// ----------------------------------------------------------------------------
module ipv4_tx_header_builder_tb;

    localparam int         MAX_PACKET       = 1500;
    localparam int         PAYLOAD_LIMIT    = MAX_PACKET - int'(ipv4tx_pkg::HDR_BYTES);
    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam logic [7:0] PROTO_ICMP       = 8'd1;
    localparam logic [7:0] PROTO_TCP        = 8'd6;
    localparam logic [7:0] PROTO_UDP        = 8'd17;
    localparam int         PHASE_REQUESTS   = 26;
    localparam int         SETTLE_CYCLES    = 8;
    localparam int         QUIET_LIMIT      = 2000;

    logic        clk                 = 1'b0;
    logic        rst_n               = 1'b0;
    logic        in_valid            = 1'b0;
    logic        in_stall;
    logic [31:0] destination_address = '0;
    logic [7:0]  protocol_number     = '0;
    logic [15:0] payload_bytes       = '0;
    logic        out_valid;
    logic        out_stall           = 1'b0;
    logic [31:0] header_word;
    logic [2:0]  word_number;
    logic        last_word;
    logic [31:0] forward_address;
    logic        length_error;
    logic        cfg_write_enable    = 1'b0;
    logic [1:0]  cfg_index           = '0;
    logic [31:0] cfg_data            = '0;
    int          pending_results;
    int          failures;

    // Traffic shaping and the register values in force, for picking destinations.
    logic        sender_gaps     = 1'b0;
    logic        receiver_stalls = 1'b0;
    int          burst_left      = 0;
    int          stall_run       = 0;
    logic [31:0] cur_local       = ipv4tx_pkg::RESET_LOCAL_ADDRESS;
    logic [31:0] cur_mask        = ipv4tx_pkg::RESET_SUBNET_MASK;

    always #2 clk = ~clk;

    ipv4_tx_header_builder #(
        .MAX_PACKET(MAX_PACKET)
    ) DUT (.*);

    ipv4_tx_header_checker #(
        .MAX_PACKET(MAX_PACKET)
    ) header_checker (.*);

    // Receiver holds out_stall for runs of random length, each run stalled or open at random.
    always @(posedge clk)
    begin
        if (stall_run > 0)
            stall_run <= stall_run - 1;
        else
        begin
            out_stall <= receiver_stalls && ($urandom_range(0, 2) == 0);
            stall_run <= $urandom_range(0, 5);
        end
    end

    // Present one request and hold it until the transaction is accepted.
    task automatic send_request(input logic [31:0] dst, input logic [7:0] proto,
                                input logic [15:0] len);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 10);
            gap = sender_gaps ? $urandom_range(1, 12) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid            <= 1'b1;
        destination_address <= dst;
        protocol_number     <= proto;
        payload_bytes       <= len;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Stop sending and wait until every predicted word has come out.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all three registers, then poke the index that has no register.
    task automatic write_registers(input logic [31:0] own, input logic [31:0] mask,
                                   input logic [31:0] gateway, input logic [31:0] junk);
        cfg_write_enable <= 1'b1;
        cfg_index        <= ipv4tx_pkg::CFG_LOCAL_ADDRESS;
        cfg_data         <= own;
        @(posedge clk);
        cfg_index <= ipv4tx_pkg::CFG_SUBNET_MASK;
        cfg_data  <= mask;
        @(posedge clk);
        cfg_index <= ipv4tx_pkg::CFG_GATEWAY_ADDRESS;
        cfg_data  <= gateway;
        @(posedge clk);
        cfg_index <= CFG_UNUSED_INDEX;
        cfg_data  <= junk;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        cur_local = own;
        cur_mask  = mask;
    endtask

    // Destinations: on the subnet, equal to the own address, or anywhere.
    function automatic logic [31:0] pick_destination();
        case ($urandom_range(0, 5))
            0, 1:    return (cur_local & cur_mask) | ($urandom() & ~cur_mask);
            2:       return cur_local;
            default: return $urandom();
        endcase
    endfunction

    // Payloads: mostly legal, with the limit and some oversized lengths.
    function automatic logic [15:0] pick_payload();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom_range(PAYLOAD_LIMIT + 1, 65535));
            1:       return 16'(PAYLOAD_LIMIT);
            2:       return 16'(PAYLOAD_LIMIT + 1);
            3:       return 16'd0;
            default: return 16'($urandom_range(0, PAYLOAD_LIMIT));
        endcase
    endfunction

    task automatic send_random_requests(input int count);
        repeat (count)
            send_request(pick_destination(), 8'($urandom()), pick_payload());
    endtask

    initial
    begin : stimulus
        logic [31:0] sum;
        logic [31:0] zero_sum_dst;
        int          prefix;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First request after reset uses identification 1; pick the low half of
        // the destination so that the header sums to all ones and the checksum is zero.
        sum = {ipv4tx_pkg::VER_IHL, 8'h00} + ipv4tx_pkg::HDR_BYTES + 32'd100
            + ipv4tx_pkg::RESET_IDENT + {ipv4tx_pkg::TTL_DEFAULT, PROTO_UDP}
            + ipv4tx_pkg::RESET_LOCAL_ADDRESS[31:16]
            + ipv4tx_pkg::RESET_LOCAL_ADDRESS[15:0] + 32'h0A00;
        sum = {16'h0000, sum[15:0]} + {16'h0000, sum[31:16]};
        sum = {16'h0000, sum[15:0]} + {16'h0000, sum[31:16]};
        zero_sum_dst = {16'h0A00, 16'hFFFF - sum[15:0]};

        // Directed requests at reset settings, no idling.
        send_request(zero_sum_dst, PROTO_UDP, 16'd100);
        send_request(32'h0A00_0201, PROTO_ICMP, 16'd0);
        send_request(32'h0808_0808, PROTO_TCP, 16'(PAYLOAD_LIMIT));
        send_request(32'h0808_0808, PROTO_TCP, 16'(PAYLOAD_LIMIT + 1));
        send_request(32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
        send_request(32'h0000_0000, 8'h00, 16'd1);
        send_request(32'hFFFF_FFFF, 8'hFF, 16'd1234);
        send_request(ipv4tx_pkg::RESET_LOCAL_ADDRESS, PROTO_UDP, 16'd8);
        send_request(ipv4tx_pkg::RESET_GATEWAY_ADDRESS, PROTO_TCP, 16'd40);
        send_request(32'h0A00_02FF, PROTO_UDP, 16'h0155);
        send_request(32'h0A00_0300, PROTO_ICMP, 16'h0AAA);
        send_request(32'hAAAA_5555, 8'hAA, 16'h8000);
        send_request(32'h5555_AAAA, 8'h55, 16'h0555);
        send_request(32'h0A00_0200, PROTO_TCP, 16'h7FFF);
        send_request(32'h0A00_02AA, 8'h80, 16'h02AA);

        // All registers at zero: every destination is on the subnet.
        wait_idle();
        write_registers(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        sender_gaps     <= 1'b1;
        receiver_stalls <= 1'b1;
        send_random_requests(PHASE_REQUESTS);

        // All registers at ones: only the own address is on the subnet.
        wait_idle();
        write_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        sender_gaps     <= 1'b1;
        receiver_stalls <= 1'b0;
        send_random_requests(PHASE_REQUESTS);

        // Random addresses with a random prefix mask.
        wait_idle();
        prefix = $urandom_range(0, 32);
        write_registers($urandom(), (prefix == 0) ? 32'd0 : 32'hFFFF_FFFF << (32 - prefix),
                        $urandom(), $urandom());
        sender_gaps     <= 1'b0;
        receiver_stalls <= 1'b1;
        send_random_requests(PHASE_REQUESTS);

        // Random addresses with an arbitrary, non-prefix mask.
        wait_idle();
        write_registers($urandom(), $urandom(), $urandom(), $urandom());
        sender_gaps     <= 1'b1;
        receiver_stalls <= 1'b1;
        send_random_requests(PHASE_REQUESTS);

        wait_idle();
        if (failures == 0 && pending_results == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // End the run if no transaction of any kind moves for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_enable)
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
